FILE: rtl/trixy_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package trixy_pkg;

	// Fixed point format shared by ranges, anchors and positions
	localparam int FRAC_BITS = 16;

	// Field widths
	localparam int AW = 24;
	localparam int RW = 24;
	localparam int PW = 32;
	localparam int SW = 2;
	localparam int CFG_IW = 3;

	// Internal widths
	localparam int DIFF_W = AW + 1;
	localparam int SQ_W = 52;

	// Limb multiplier: signed MUL_AW x signed MUL_BW, limbs of LIMB bits
	localparam int LIMB = 26;
	localparam int MUL_AW = 52;
	localparam int MUL_BW = 104;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam int MUL_PPW = 2 * (LIMB + 1);
	localparam int MUL_LAT = 4;

	// Rounding divider: numerator, doubled denominator, quotient
	localparam int NUM_W = 128;
	localparam int DEN_W = 100;
	localparam int QUO_W = 40;
	localparam int DIV_LAT = QUO_W + 1;

	// Configuration hold-off after a write
	localparam int HOLD_W = 3;
	localparam logic [HOLD_W-1:0] CFG_HOLD = HOLD_W'(4);

	// Anchor reset positions
	localparam logic signed [AW-1:0] A1X_RST = AW'(10 * (1 << FRAC_BITS));
	localparam logic signed [AW-1:0] A1Y_RST = AW'(10 * (1 << FRAC_BITS));
	localparam logic signed [AW-1:0] A2X_RST = AW'(-10 * (1 << FRAC_BITS));
	localparam logic signed [AW-1:0] A2Y_RST = AW'(10 * (1 << FRAC_BITS));
	localparam logic signed [AW-1:0] A3X_RST = AW'(0);
	localparam logic signed [AW-1:0] A3Y_RST = AW'(-14 * (1 << FRAC_BITS));

	typedef enum logic [CFG_IW-1:0] {
		REG_A1X,
		REG_A1Y,
		REG_A2X,
		REG_A2Y,
		REG_A3X,
		REG_A3Y
	} cfg_reg_t;

	typedef enum logic [SW-1:0] {
		ST_OK,
		ST_DEGEN,
		ST_SAT
	} status_t;

endpackage
`default_nettype wire

FILE: rtl/three_anchor_trilateration_xy_unit.sv
// Throughput: one request per cycle while range_stall is low; limb multipliers and a
// divider (one quotient bit per stage) are fully pipelined, and a stalled result waits
// in a two-entry output buffer. A configuration write holds off requests until hold_q clears.
// Reset: anchors return to their default positions, all valid bits clear, and
// requests are held off while the anchor geometry settles.
`timescale 1ns / 1ps
`default_nettype none
module three_anchor_trilateration_xy_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [trixy_pkg::CFG_IW-1:0] cfg_index,
	input  logic [trixy_pkg::AW-1:0] cfg_data,
	input  logic range_valid,
	output logic range_stall,
	input  logic [trixy_pkg::RW-1:0] range_one,
	input  logic [trixy_pkg::RW-1:0] range_two,
	input  logic [trixy_pkg::RW-1:0] range_three,
	output logic pos_valid,
	input  logic pos_stall,
	output logic signed [trixy_pkg::PW-1:0] pos_x,
	output logic signed [trixy_pkg::PW-1:0] pos_y,
	output logic [trixy_pkg::SW-1:0] status
);
	import trixy_pkg::*;

	localparam int PRE_DIV = 2 + MUL_LAT + 1 + MUL_LAT + 2;
	localparam int PIPE_N = PRE_DIV + DIV_LAT + 1;
	localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};

	// Anchor registers and derived geometry
	logic signed [AW-1:0] a1x_q, a1y_q, a2x_q, a2y_q, a3x_q, a3y_q;
	logic signed [DIFF_W-1:0] ux_q, uy_q, vx_q, vy_q;
	logic signed [2*DIFF_W-1:0] uxux_c, uyuy_c, uxvx_c, uyvy_c;
	logic signed [2*DIFF_W-1:0] uxvy_c, uyvx_c, vxvx_c, vyvy_c;
	logic signed [SQ_W-1:0] dd_q, dot_q, cr_q, vv_q;
	logic signed [MUL_PW-1:0] den_p;
	logic [DEN_W-1:0] ad_q;
	logic [DEN_W-1:0] dsor_q;
	logic deg_q;
	logic [HOLD_W-1:0] hold_q;

	// Pipeline
	logic en;
	logic accept;
	logic vld_q [PIPE_N];
	logic [2*RW-1:0] r1sq_c, r2sq_c, r3sq_c;
	logic [2*RW-1:0] r1sq_s1, r2sq_s1, r3sq_s1;
	logic signed [SQ_W-1:0] bb_s2, aa_s2;
	logic signed [MUL_PW-1:0] wbc_p, add_p, dbb_p;
	logic signed [MUL_PW-1:0] we_c;
	logic signed [MUL_BW-1:0] wbc_s7, we_s7;
	logic signed [MUL_PW-1:0] t1_p, t2_p, t3_p, t4_p;
	logic signed [MUL_PW-1:0] nx_c, ny_c;
	logic signed [NUM_W-1:0] nx_s12, ny_s12;
	logic [NUM_W-1:0] anx_c, any_c;
	logic [NUM_W-1:0] numx_s13, numy_s13;
	logic negx_s13, negy_s13;
	logic negx_dly_q [DIV_LAT];
	logic negy_dly_q [DIV_LAT];
	logic [QUO_W-1:0] qx, qy;
	logic bigx, bigy;
	logic [PW:0] fx_c, fy_c;
	logic signed [PW-1:0] px_s55, py_s55;
	status_t st_s55;

	// Output buffer
	logic arrive, fire;
	logic out_v_q, skid_v_q;
	logic signed [PW-1:0] px_q, py_q, skid_x_q, skid_y_q;
	status_t st_q, skid_st_q;

	// Round-to-nearest result placed on its anchor base, clamped; returns {sat, value}
	function automatic logic [PW:0] place(logic signed [AW-1:0] base,
			logic [QUO_W-1:0] q, logic neg, logic big);
		logic signed [QUO_W+1:0] sq;
		logic signed [QUO_W+1:0] v;
		logic [PW:0] r;
		sq = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
		v = sq + (QUO_W+2)'(base);
		if (big) begin
			r = {1'b1, neg ? PMIN : PMAX};
		end else if (v > (QUO_W+2)'(PMAX)) begin
			r = {1'b1, PMAX};
		end else if (v < (QUO_W+2)'(PMIN)) begin
			r = {1'b1, PMIN};
		end else begin
			r = {1'b0, v[PW-1:0]};
		end
		return r;
	endfunction

	// Hold anchor writes; ignore indexes past the last register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a1x_q <= A1X_RST;
			a1y_q <= A1Y_RST;
			a2x_q <= A2X_RST;
			a2y_q <= A2Y_RST;
			a3x_q <= A3X_RST;
			a3y_q <= A3Y_RST;
			hold_q <= CFG_HOLD;
		end else begin
			if (cfg_we) begin
				hold_q <= CFG_HOLD;
				case (cfg_reg_t'(cfg_index))
					REG_A1X: a1x_q <= cfg_data;
					REG_A1Y: a1y_q <= cfg_data;
					REG_A2X: a2x_q <= cfg_data;
					REG_A2Y: a2y_q <= cfg_data;
					REG_A3X: a3x_q <= cfg_data;
					REG_A3Y: a3y_q <= cfg_data;
					default: ;
				endcase
			end else if (hold_q != '0) begin
				hold_q <= hold_q - HOLD_W'(1);
			end
		end
	end

	// Anchor-only products
	assign uxux_c = ux_q * ux_q;
	assign uyuy_c = uy_q * uy_q;
	assign uxvx_c = ux_q * vx_q;
	assign uyvy_c = uy_q * vy_q;
	assign uxvy_c = ux_q * vy_q;
	assign uyvx_c = uy_q * vx_q;
	assign vxvx_c = vx_q * vx_q;
	assign vyvy_c = vy_q * vy_q;

	always_ff @(posedge clk) begin
		ux_q <= DIFF_W'(a2x_q) - DIFF_W'(a1x_q);
		uy_q <= DIFF_W'(a2y_q) - DIFF_W'(a1y_q);
		vx_q <= DIFF_W'(a3x_q) - DIFF_W'(a1x_q);
		vy_q <= DIFF_W'(a3y_q) - DIFF_W'(a1y_q);
		dd_q <= SQ_W'(uxux_c) + SQ_W'(uyuy_c);
		dot_q <= SQ_W'(uxvx_c) + SQ_W'(uyvy_c);
		cr_q <= SQ_W'(uxvy_c) - SQ_W'(uyvx_c);
		vv_q <= SQ_W'(vxvx_c) + SQ_W'(vyvy_c);
		deg_q <= (cr_q == '0);
		// den = 2*cr*|u|^2, kept as magnitude and doubled magnitude
		ad_q <= den_p[MUL_PW-1] ? DEN_W'(-den_p) : DEN_W'(den_p);
		dsor_q <= (den_p[MUL_PW-1] ? DEN_W'(-den_p) : DEN_W'(den_p)) << 1;
	end

	trixy_mul u_mul_den (
		.clk (clk),
		.en  (1'b1),
		.a   (cr_q <<< 1),
		.b   (MUL_BW'(dd_q)),
		.p   (den_p)
	);

	// Request handshake and pipeline advance
	assign en = ~skid_v_q;
	assign range_stall = skid_v_q | (hold_q != '0);
	assign accept = range_valid & ~range_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIPE_N; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= accept;
			for (int k = 1; k < PIPE_N; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// Range squares, then the two linear right-hand sides
	assign r1sq_c = range_one * range_one;
	assign r2sq_c = range_two * range_two;
	assign r3sq_c = range_three * range_three;

	always_ff @(posedge clk) begin
		if (en) begin
			r1sq_s1 <= r1sq_c;
			r2sq_s1 <= r2sq_c;
			r3sq_s1 <= r3sq_c;
			bb_s2 <= SQ_W'(r1sq_s1) - SQ_W'(r2sq_s1) + dd_q;
			aa_s2 <= SQ_W'(r1sq_s1) - SQ_W'(r3sq_s1) + vv_q;
		end
	end

	// B*C, A*|u|^2 and (u.v)*B
	trixy_mul u_mul_wbc (
		.clk (clk),
		.en  (en),
		.a   (bb_s2),
		.b   (MUL_BW'(cr_q)),
		.p   (wbc_p)
	);

	trixy_mul u_mul_add (
		.clk (clk),
		.en  (en),
		.a   (aa_s2),
		.b   (MUL_BW'(dd_q)),
		.p   (add_p)
	);

	trixy_mul u_mul_dbb (
		.clk (clk),
		.en  (en),
		.a   (dot_q),
		.b   (MUL_BW'(bb_s2)),
		.p   (dbb_p)
	);

	assign we_c = add_p - dbb_p;

	always_ff @(posedge clk) begin
		if (en) begin
			wbc_s7 <= wbc_p[MUL_BW-1:0];
			we_s7 <= we_c[MUL_BW-1:0];
		end
	end

	// Rotate back onto u and perp(u)
	trixy_mul u_mul_t1 (
		.clk (clk),
		.en  (en),
		.a   (MUL_AW'(ux_q)),
		.b   (wbc_s7),
		.p   (t1_p)
	);

	trixy_mul u_mul_t2 (
		.clk (clk),
		.en  (en),
		.a   (MUL_AW'(uy_q)),
		.b   (we_s7),
		.p   (t2_p)
	);

	trixy_mul u_mul_t3 (
		.clk (clk),
		.en  (en),
		.a   (MUL_AW'(uy_q)),
		.b   (wbc_s7),
		.p   (t3_p)
	);

	trixy_mul u_mul_t4 (
		.clk (clk),
		.en  (en),
		.a   (MUL_AW'(ux_q)),
		.b   (we_s7),
		.p   (t4_p)
	);

	assign nx_c = t1_p - t2_p;
	assign ny_c = t3_p + t4_p;
	assign anx_c = nx_s12[NUM_W-1] ? NUM_W'(-nx_s12) : NUM_W'(nx_s12);
	assign any_c = ny_s12[NUM_W-1] ? NUM_W'(-ny_s12) : NUM_W'(ny_s12);

	// Numerators, rounding offset and sign for the divider
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s12 <= nx_c[NUM_W-1:0];
			ny_s12 <= ny_c[NUM_W-1:0];
			numx_s13 <= (anx_c << 1) + NUM_W'(ad_q);
			numy_s13 <= (any_c << 1) + NUM_W'(ad_q);
			negx_s13 <= nx_s12[NUM_W-1] ^ cr_q[SQ_W-1];
			negy_s13 <= ny_s12[NUM_W-1] ^ cr_q[SQ_W-1];
			negx_dly_q[0] <= negx_s13;
			negy_dly_q[0] <= negy_s13;
			for (int k = 1; k < DIV_LAT; k++) begin
				negx_dly_q[k] <= negx_dly_q[k-1];
				negy_dly_q[k] <= negy_dly_q[k-1];
			end
		end
	end

	trixy_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (numx_s13),
		.den (dsor_q),
		.quo (qx),
		.big (bigx)
	);

	trixy_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (numy_s13),
		.den (dsor_q),
		.quo (qy),
		.big (bigy)
	);

	// Place on anchor 1, clamp, flag
	assign fx_c = place(a1x_q, qx, negx_dly_q[DIV_LAT-1], bigx);
	assign fy_c = place(a1y_q, qy, negy_dly_q[DIV_LAT-1], bigy);

	always_ff @(posedge clk) begin
		if (en) begin
			if (deg_q) begin
				px_s55 <= '0;
				py_s55 <= '0;
				st_s55 <= ST_DEGEN;
			end else begin
				px_s55 <= fx_c[PW-1:0];
				py_s55 <= fy_c[PW-1:0];
				st_s55 <= (fx_c[PW] | fy_c[PW]) ? ST_SAT : ST_OK;
			end
		end
	end

	// Output register with a skid entry behind it
	assign arrive = en & vld_q[PIPE_N-1];
	assign fire = out_v_q & ~pos_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (arrive) begin
			if (~out_v_q | fire) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (fire) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (arrive & (~out_v_q | fire)) begin
			px_q <= px_s55;
			py_q <= py_s55;
			st_q <= st_s55;
		end else if (arrive) begin
			skid_x_q <= px_s55;
			skid_y_q <= py_s55;
			skid_st_q <= st_s55;
		end else if (fire & skid_v_q) begin
			px_q <= skid_x_q;
			py_q <= skid_y_q;
			st_q <= skid_st_q;
		end
	end

	assign pos_valid = out_v_q;
	assign pos_x = px_q;
	assign pos_y = py_q;
	assign status = st_q;

endmodule
`default_nettype wire

FILE: rtl/trixy_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module trixy_mul (
	input  logic clk,
	input  logic en,
	input  logic signed [trixy_pkg::MUL_AW-1:0] a,
	input  logic signed [trixy_pkg::MUL_BW-1:0] b,
	output logic signed [trixy_pkg::MUL_PW-1:0] p
);
	import trixy_pkg::*;

	localparam int NA = MUL_AW / LIMB;
	localparam int NB = MUL_BW / LIMB;

	logic signed [LIMB:0] ae [NA];
	logic signed [LIMB:0] be [NB];
	logic signed [MUL_PPW-1:0] pp_s1 [NA][NB];
	logic signed [MUL_PW-1:0] col_c [NB];
	logic signed [MUL_PW-1:0] col_s2 [NB];
	logic signed [MUL_PW-1:0] lo_s3;
	logic signed [MUL_PW-1:0] hi_s3;

	function automatic logic signed [MUL_PW-1:0] pp_ext(logic signed [MUL_PPW-1:0] v);
		return {{(MUL_PW-MUL_PPW){v[MUL_PPW-1]}}, v};
	endfunction

	// Split operands: top limb signed, lower limbs unsigned
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			if (i == NA - 1) begin
				ae[i] = $signed({a[i*LIMB+LIMB-1], a[i*LIMB +: LIMB]});
			end else begin
				ae[i] = $signed({1'b0, a[i*LIMB +: LIMB]});
			end
		end
		for (int j = 0; j < NB; j++) begin
			if (j == NB - 1) begin
				be[j] = $signed({b[j*LIMB+LIMB-1], b[j*LIMB +: LIMB]});
			end else begin
				be[j] = $signed({1'b0, b[j*LIMB +: LIMB]});
			end
		end
	end

	// Gather the A limbs of each B column
	always_comb begin
		for (int j = 0; j < NB; j++) begin
			col_c[j] = '0;
			for (int i = 0; i < NA; i++) begin
				col_c[j] = col_c[j] + (pp_ext(pp_s1[i][j]) <<< (i * LIMB));
			end
		end
	end

	// Partial products, columns, halves, final sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= ae[i] * be[j];
				end
			end
			col_s2 <= col_c;
			lo_s3 <= col_s2[0] + (col_s2[1] <<< LIMB);
			hi_s3 <= col_s2[2] + (col_s2[3] <<< LIMB);
			p <= lo_s3 + (hi_s3 <<< (2 * LIMB));
		end
	end

endmodule
`default_nettype wire

FILE: rtl/trixy_div.sv
`timescale 1ns / 1ps
`default_nettype none
module trixy_div (
	input  logic clk,
	input  logic en,
	input  logic [trixy_pkg::NUM_W-1:0] num,
	input  logic [trixy_pkg::DEN_W-1:0] den,
	output logic [trixy_pkg::QUO_W-1:0] quo,
	output logic big
);
	import trixy_pkg::*;

	logic [DEN_W-1:0] rem_s [QUO_W+1];
	logic [QUO_W-1:0] low_s [QUO_W+1];
	logic [QUO_W-1:0] q_s [QUO_W+1];
	logic big_s [QUO_W+1];
	logic [DEN_W-1:0] rem_n [QUO_W+1];
	logic qbit_n [QUO_W+1];

	// One restoring step per stage, each on its own stage's remainder
	always_comb begin
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		rem_n[0] = '0;
		qbit_n[0] = 1'b0;
		for (int k = 1; k <= QUO_W; k++) begin
			trial = {rem_s[k-1], low_s[k-1][QUO_W-1]};
			diff = trial - {1'b0, den};
			qbit_n[k] = ~diff[DEN_W];
			rem_n[k] = diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
		end
	end

	// Load the top of the numerator and flag a quotient past QUO_W bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DEN_W'(num[NUM_W-1:QUO_W]);
			low_s[0] <= num[QUO_W-1:0];
			q_s[0] <= '0;
			big_s[0] <= (DEN_W'(num[NUM_W-1:QUO_W]) >= den);
			for (int k = 1; k <= QUO_W; k++) begin
				rem_s[k] <= rem_n[k];
				low_s[k] <= low_s[k-1] << 1;
				q_s[k] <= {q_s[k-1][QUO_W-2:0], qbit_n[k]};
				big_s[k] <= big_s[k-1];
			end
		end
	end

	assign quo = q_s[QUO_W];
	assign big = big_s[QUO_W];

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import trixy_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int ITEMS_PER_PHASE = 100;
	localparam logic [CFG_IW-1:0] REG_SPARE_LO = CFG_IW'(6);
	localparam logic [CFG_IW-1:0] REG_SPARE_HI = CFG_IW'(7);
	localparam logic [RW-1:0] RMAX = '1;
	localparam int ONE_M = 1 << FRAC_BITS;

	typedef logic signed [255:0] big_t;

	typedef struct {
		logic signed [PW-1:0] x;
		logic signed [PW-1:0] y;
		status_t st;
	} fix_t;

	typedef struct {
		logic [RW-1:0] r1;
		logic [RW-1:0] r2;
		logic [RW-1:0] r3;
		bit typed;
		fix_t want;
	} range_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [AW-1:0] cfg_data = '0;
	logic range_valid = 1'b0;
	logic range_stall;
	logic [RW-1:0] range_one = '0;
	logic [RW-1:0] range_two = '0;
	logic [RW-1:0] range_three = '0;
	logic pos_valid;
	logic pos_stall = 1'b0;
	logic signed [PW-1:0] pos_x;
	logic signed [PW-1:0] pos_y;
	logic [SW-1:0] status;

	logic signed [AW-1:0] anchor [6];
	fix_t fix_q [$];
	int send_idle = 0;
	int recv_idle = 0;
	int errors = 0;
	int fixes_seen = 0;
	int degen_seen = 0;
	int sat_seen = 0;
	int requests_sent = 0;
	int cycles = 0;

	range_row_t opening [12];

	three_anchor_trilateration_xy_unit uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending", cycles, fix_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Round base + num/den to nearest, ties away from zero, clamp to 32 bits
	function automatic logic signed [PW-1:0] place_axis(input big_t base, input big_t num,
			input big_t den, inout bit sat);
		big_t an, ad, q, val;
		bit neg;
		neg = (num < 0) != (den < 0);
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		q = (2 * an + ad) / (2 * ad);
		if (q >= (big_t'(1) <<< 40)) begin
			sat = 1'b1;
			return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		val = (neg ? -q : q) + base;
		if (val > big_t'(32'sh7fff_ffff)) begin
			sat = 1'b1;
			return 32'sh7fff_ffff;
		end
		if (val < big_t'(32'sh8000_0000)) begin
			sat = 1'b1;
			return 32'sh8000_0000;
		end
		return val[PW-1:0];
	endfunction

	// Solve the planar position from three ranges with the current anchors
	function automatic fix_t solve_position(input logic [RW-1:0] r1, input logic [RW-1:0] r2,
			input logic [RW-1:0] r3);
		big_t x1, y1, ux, uy, vx, vy, a1, a2, a3, dd, dt, cr, bb, aa, wbc, we, nx, ny, den;
		fix_t f;
		bit sat;
		x1 = anchor[REG_A1X];
		y1 = anchor[REG_A1Y];
		ux = big_t'(anchor[REG_A2X]) - x1;
		uy = big_t'(anchor[REG_A2Y]) - y1;
		vx = big_t'(anchor[REG_A3X]) - x1;
		vy = big_t'(anchor[REG_A3Y]) - y1;
		a1 = big_t'({1'b0, r1});
		a2 = big_t'({1'b0, r2});
		a3 = big_t'({1'b0, r3});
		dd = ux * ux + uy * uy;
		dt = ux * vx + uy * vy;
		cr = ux * vy - uy * vx;
		f.x = '0;
		f.y = '0;
		f.st = ST_DEGEN;
		if (cr == 0)
			return f;
		bb = a1 * a1 - a2 * a2 + dd;
		aa = a1 * a1 - a3 * a3 + vx * vx + vy * vy;
		wbc = bb * cr;
		we = aa * dd - dt * bb;
		nx = ux * wbc - uy * we;
		ny = uy * wbc + ux * we;
		den = 2 * cr * dd;
		sat = 1'b0;
		f.x = place_axis(x1, nx, den, sat);
		f.y = place_axis(y1, ny, den, sat);
		f.st = sat ? ST_SAT : ST_OK;
		return f;
	endfunction

	// Write one anchor register while the block is idle
	task automatic write_anchor(input logic [CFG_IW-1:0] idx, input logic [AW-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx < CFG_IW'(6))
			anchor[idx] = val;
	endtask

	task automatic place_anchors(input int a1x, input int a1y, input int a2x, input int a2y,
			input int a3x, input int a3y);
		write_anchor(REG_A1X, AW'(a1x));
		write_anchor(REG_A1Y, AW'(a1y));
		write_anchor(REG_A2X, AW'(a2x));
		write_anchor(REG_A2Y, AW'(a2y));
		write_anchor(REG_A3X, AW'(a3x));
		write_anchor(REG_A3Y, AW'(a3y));
	endtask

	// Offer one range request and queue its expected fix once accepted
	task automatic send_ranges(input logic [RW-1:0] r1, input logic [RW-1:0] r2,
			input logic [RW-1:0] r3, input bit typed, input fix_t want);
		while ($urandom_range(99) < send_idle) begin
			@(negedge clk);
			range_valid = 1'b0;
		end
		@(negedge clk);
		range_valid = 1'b1;
		range_one = r1;
		range_two = r2;
		range_three = r3;
		do @(posedge clk); while (!(range_valid && !range_stall));
		fix_q.insert(fix_q.size(), typed ? want : solve_position(r1, r2, r3));
		requests_sent++;
	endtask

	// Hold off the sender until every pending fix has drained
	task automatic drain_fixes();
		@(negedge clk);
		range_valid = 1'b0;
		while (fix_q.size() != 0)
			@(posedge clk);
	endtask

	// Random ranges: mostly measured from a real point, some raw noise
	task automatic random_ranges(input int count);
		real px, py, d1, d2, d3;
		logic [RW-1:0] r [3];
		fix_t none;
		none = '{default: '0, st: ST_OK};
		repeat (count) begin
			if ($urandom_range(99) < 70) begin
				px = ($itor($urandom_range(8000)) - 4000.0) / 50.0 * ONE_M;
				py = ($itor($urandom_range(8000)) - 4000.0) / 50.0 * ONE_M;
				d1 = $sqrt((px - anchor[REG_A1X]) ** 2 + (py - anchor[REG_A1Y]) ** 2);
				d2 = $sqrt((px - anchor[REG_A2X]) ** 2 + (py - anchor[REG_A2Y]) ** 2);
				d3 = $sqrt((px - anchor[REG_A3X]) ** 2 + (py - anchor[REG_A3Y]) ** 2);
				r[0] = (d1 > 16777215.0) ? RMAX : RW'($rtoi(d1 + 0.5) + $urandom_range(3));
				r[1] = (d2 > 16777215.0) ? RMAX : RW'($rtoi(d2 + 0.5) + $urandom_range(3));
				r[2] = (d3 > 16777215.0) ? RMAX : RW'($rtoi(d3 + 0.5) + $urandom_range(3));
			end else if ($urandom_range(3) == 0) begin
				r[0] = RW'($urandom_range(64));
				r[1] = $urandom_range(1) ? RMAX : RW'(0);
				r[2] = RW'($urandom);
			end else begin
				r[0] = RW'($urandom);
				r[1] = RW'($urandom);
				r[2] = RW'($urandom);
			end
			send_ranges(r[0], r[1], r[2], 1'b0, none);
		end
	endtask

	// Receiver: stall at random, compare each accepted fix with the oldest expectation
	always @(negedge clk)
		pos_stall <= ($urandom_range(99) < recv_idle);

	always @(posedge clk) begin
		fix_t w;
		if (arst_n && pos_valid && !pos_stall) begin
			if (fix_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected fix x=%0d y=%0d status=%0d", pos_x, pos_y, status);
			end else begin
				w = fix_q.pop_front();
				fixes_seen++;
				if (w.st == ST_DEGEN)
					degen_seen++;
				if (w.st == ST_SAT)
					sat_seen++;
				if (pos_x !== w.x || pos_y !== w.y || status !== w.st) begin
					errors++;
					if (errors <= 10)
						$display("Fix %0d mismatch: x=%0d/%0d y=%0d/%0d status=%0d/%0d",
							fixes_seen, pos_x, w.x, pos_y, w.y, status, w.st);
				end
			end
		end
	end

	initial begin
		fix_t none;
		none = '{default: '0, st: ST_OK};
		anchor[REG_A1X] = A1X_RST;
		anchor[REG_A1Y] = A1Y_RST;
		anchor[REG_A2X] = A2X_RST;
		anchor[REG_A2Y] = A2Y_RST;
		anchor[REG_A3X] = A3X_RST;
		anchor[REG_A3Y] = A3Y_RST;

		// Opening rows on the default anchors; the first sits exactly on anchor one
		opening[0] = '{0, 20 * ONE_M, 26 * ONE_M, 1'b1,
			'{x: 10 * ONE_M, y: 10 * ONE_M, st: ST_OK}};
		opening[1] = '{0, 0, 0, 1'b0, none};
		opening[2] = '{RMAX, RMAX, RMAX, 1'b0, none};
		opening[3] = '{RMAX, 0, 0, 1'b0, none};
		opening[4] = '{0, RMAX, 0, 1'b0, none};
		opening[5] = '{0, 0, RMAX, 1'b0, none};
		opening[6] = '{24'h555555, 24'haaaaaa, 24'h555555, 1'b0, none};
		opening[7] = '{24'haaaaaa, 24'h555555, 24'haaaaaa, 1'b0, none};
		opening[8] = '{1, 1, 1, 1'b0, none};
		opening[9] = '{RMAX, 1, RMAX, 1'b0, none};
		opening[10] = '{20 * ONE_M, 0, 20 * ONE_M, 1'b0, none};
		opening[11] = '{5 * ONE_M, 5 * ONE_M, 90 * ONE_M, 1'b0, none};

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Default anchors, sender idles lightly and receiver heavily
		send_idle = 34;
		recv_idle = 81;
		foreach (opening[k])
			send_ranges(opening[k].r1, opening[k].r2, opening[k].r3, opening[k].typed,
				opening[k].want);
		random_ranges(ITEMS_PER_PHASE - 12);
		drain_fixes();

		// Extreme anchors spanning the whole register range; spare indexes are ignored
		place_anchors(-8388608, -8388608, 8388607, -8388608, 0, 8388607);
		write_anchor(REG_SPARE_LO, 24'h123456);
		write_anchor(REG_SPARE_HI, 24'hfedcba);
		send_ranges(0, 0, 0, 1'b0, none);
		send_ranges(RMAX, RMAX, RMAX, 1'b0, none);
		random_ranges(ITEMS_PER_PHASE);
		drain_fixes();

		// Nearly collinear anchors push fixes into saturation
		send_idle = 81;
		recv_idle = 34;
		place_anchors(0, 0, ONE_M, 0, 8388607, 1);
		send_ranges(RMAX, 0, 0, 1'b0, none);
		send_ranges(0, RMAX, RMAX, 1'b0, none);
		random_ranges(ITEMS_PER_PHASE);
		drain_fixes();

		// Coincident first two anchors, then all three collinear
		place_anchors(3 * ONE_M, -2 * ONE_M, 3 * ONE_M, -2 * ONE_M, 0, 0);
		send_ranges(0, 0, 0, 1'b0, none);
		random_ranges(ITEMS_PER_PHASE / 4);
		drain_fixes();
		place_anchors(-ONE_M, -ONE_M, ONE_M, ONE_M, 4 * ONE_M, 4 * ONE_M);
		send_ranges(RMAX, RMAX, RMAX, 1'b0, none);
		random_ranges(ITEMS_PER_PHASE / 4);
		drain_fixes();

		// Two random anchor sets, then one extreme set, no idling on either side
		send_idle = 0;
		recv_idle = 0;
		repeat (2) begin
			place_anchors($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			random_ranges(ITEMS_PER_PHASE);
			drain_fixes();
		end
		place_anchors(8388607, 8388607, -8388608, 8388607, 0, -8388608);
		random_ranges(ITEMS_PER_PHASE / 2);
		drain_fixes();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d range requests over eight anchor settings and three idling modes",
			requests_sent);
		$display("Checked %0d fixes: %0d degenerate, %0d saturated", fixes_seen, degen_seen,
			sat_seen);
		if (errors == 0 && fix_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d fixes never arrived", errors, fix_q.size());
			$display("Verification failed");
		end
		$finish;
	end
endmodule
